// ===== sv/positional_list_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// positional list engine assertion macros
// shared concurrent assertion forms for the list engine checkers
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

// property checked on every rising edge, off while reset is held
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every rising edge, reset included
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== sv/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// widths, codes and shared types of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

    // fixed field widths
    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int WIDE_W   = 64;

    // parameter defaults
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REPLACE  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RETRIEVE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
        logic wr;
    } t_cell_ctrl;

endpackage

// ===== sv/ple_if.sv =====
// ----------------------------------------------------------------------------
// ple_in_if / ple_out_if
// valid/ready channels carrying request and result words
// ----------------------------------------------------------------------------
interface ple_in_if;
    import ple_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

interface ple_out_if;
    import ple_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_full;
    logic                is_empty;

    modport source (output valid, output status, output read_value,
                    output entry_count, output is_full, output is_empty,
                    input ready);
    modport sink   (input valid, input status, input read_value,
                    input entry_count, input is_full, input is_empty,
                    output ready);
endinterface

// ===== sv/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core
// packed ordered list of MAX_ENTRIES entries held in a row of register cells
// ----------------------------------------------------------------------------
// The list lives in a row of MAX_ENTRIES cells, one entry each. Every request
// word (insert, remove, replace, retrieve, clear) is finished in the cycle it
// is accepted: on insert the cells above the addressed position shift up, on
// remove the cells at or above it shift down, both in that single cycle, and
// the result word appears in the output register in the next cycle. One word
// is taken per cycle as long as the result side keeps taking results; ready
// drops only while a result waits. No clearing pass is needed after reset:
// entries above the count are never read.
module positional_list_engine_core #(
    parameter int MAX_ENTRIES = ple_pkg::MAX_ENTRIES_DEF,
    parameter int DATA_WIDTH  = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ple_in_if.sink     i_in,
    ple_out_if.source  o_out
);
    import ple_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [PW-1:0] MAX_W = PW'(MAX_ENTRIES);

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [VALUE_W-1:0]     r_read;
    logic [COUNT_W-1:0]     r_ecount;
    logic                   r_full;
    logic                   r_empty;

    logic                   accept;
    logic [PW-1:0]          pos_w;
    logic [PW-1:0]          cnt_w;
    logic [PW-1:0]          ncnt_w;
    logic [WIDE_W-1:0]      val64;
    logic [DATA_WIDTH-1:0]  val_d;
    logic [DATA_WIDTH-1:0]  rd_sel;
    logic [WIDE_W-1:0]      rd64;
    logic [STATUS_W-1:0]    status;
    logic                   give_rd;
    t_cell_ctrl             ctrl;

    logic [DATA_WIDTH-1:0]  w_data [MAX_ENTRIES];
    logic [DATA_WIDTH-1:0]  w_rd   [MAX_ENTRIES];

    // handshake: output register frees the input side
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign pos_w = PW'(i_in.position);
    assign cnt_w = PW'(r_count);
    assign val64 = WIDE_W'(i_in.value);
    assign val_d = val64[DATA_WIDTH-1:0];

    // request decode and bounds checks
    always_comb begin
        status  = ST_OK;
        give_rd = 1'b0;
        ctrl    = '0;
        n_count = r_count;
        unique case (i_in.action)
            ACT_INSERT: begin
                if (cnt_w == MAX_W) begin
                    status = ST_OVERFLOW;
                end else if (pos_w > cnt_w) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.ins = accept;
                    n_count  = r_count + CW'(1);
                end
            end
            ACT_REMOVE: begin
                if (r_count == '0) begin
                    status = ST_UNDERFLOW;
                end else if (pos_w >= cnt_w) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.rem = accept;
                    give_rd  = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            ACT_REPLACE: begin
                if (pos_w >= cnt_w) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.wr = accept;
                end
            end
            ACT_RETRIEVE: begin
                if (pos_w >= cnt_w) begin
                    status = ST_RANGE;
                end else begin
                    give_rd = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // row of cells
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_d;
        logic [DATA_WIDTH-1:0] next_d;

        if (g == 0) begin : g_first
            assign prev_d = w_data[g];
        end else begin : g_mid
            assign prev_d = w_data[g-1];
        end
        if (g == MAX_ENTRIES - 1) begin : g_last
            assign next_d = w_data[g];
        end else begin : g_up
            assign next_d = w_data[g+1];
        end

        ple_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH),
            .PW         (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_pos   (pos_w),
            .i_value (val_d),
            .i_prev  (prev_d),
            .i_next  (next_d),
            .o_data  (w_data[g]),
            .o_rd    (w_rd[g])
        );
    end

    // or-bus collecting the addressed entry
    always_comb begin
        rd_sel = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            rd_sel = rd_sel | w_rd[k];
        end
    end
    assign rd64   = give_rd ? WIDE_W'(rd_sel) : '0;
    assign ncnt_w = PW'(n_count);

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= status;
            r_read   <= rd64[VALUE_W-1:0];
            r_ecount <= ncnt_w[COUNT_W-1:0];
            r_full   <= (ncnt_w == MAX_W);
            r_empty  <= (n_count == '0);
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_status;
    assign o_out.read_value  = r_read;
    assign o_out.entry_count = r_ecount;
    assign o_out.is_full     = r_full;
    assign o_out.is_empty    = r_empty;

endmodule

// ===== sv/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds an entry and trades it with its neighbors on shifts
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32,
    parameter int PW         = 7
) (
    input  logic                   i_clk,
    input  ple_pkg::t_cell_ctrl    i_ctrl,
    input  logic [PW-1:0]          i_pos,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic [DATA_WIDTH-1:0]  i_prev,
    input  logic [DATA_WIDTH-1:0]  i_next,
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic [DATA_WIDTH-1:0]  o_rd
);
    import ple_pkg::*;

    localparam logic [PW-1:0] IDX_W = PW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  hit;
    logic                  above;

    assign hit   = (i_pos == IDX_W);
    assign above = (IDX_W > i_pos);

    // slot update: place, shift up, shift down or overwrite
    always_comb begin
        n_data = r_data;
        priority if (i_ctrl.ins && hit) begin
            n_data = i_value;
        end else if (i_ctrl.ins && above) begin
            n_data = i_prev;
        end else if (i_ctrl.rem && (hit || above)) begin
            n_data = i_next;
        end else if (i_ctrl.wr && hit) begin
            n_data = i_value;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // masked read onto the shared or-bus
    assign o_data = r_data;
    assign o_rd   = hit ? r_data : '0;

endmodule

// ===== sv/ple_checker.sv =====
// ----------------------------------------------------------------------------
// ple_checker
// port-level checks of the list engine, bound to the top level
// ----------------------------------------------------------------------------
`include "positional_list_engine_core_assert.svh"

module ple_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [ple_pkg::ACTION_W-1:0]  i_in_action,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [ple_pkg::STATUS_W-1:0]  i_out_status,
    input  logic                          i_out_full,
    input  logic                          i_out_empty
);
    import ple_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a pending result word holds until taken
    `PLE_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped before taken")

    // every accepted word yields a result next cycle
    `PLE_ASSERT(a_result_follows, i_clk, i_rst_n, in_acc |=> i_out_valid, "accepted word gave no result")

    // clear always succeeds and empties the list
    `PLE_ASSERT(a_clear_empties, i_clk, i_rst_n, in_acc && i_in_action == ACT_CLEAR |=> i_out_status == ST_OK && i_out_empty, "clear did not empty the list")

    // overflow only when full, and never full and empty at once
    `PLE_ASSERT(a_overflow_full, i_clk, i_rst_n, i_out_valid && i_out_status == ST_OVERFLOW |-> i_out_full, "overflow reported on a list not full")
    `PLE_ASSERT(a_flags_excl, i_clk, i_rst_n, i_out_valid |-> !(i_out_full && i_out_empty), "list full and empty at once")

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_action  (i_in.action),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_full   (o_out.is_full),
    .i_out_empty  (o_out.is_empty)
);
